### rtl/sha_pkg.sv
// Shared types, constants and round functions of the SHA-256 stream hasher.
package sha_pkg;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int LEN_POS = 56;
    localparam int QUEUE_DEPTH = 4;

    // One classified command from the front part to the core.
    typedef struct packed {
        logic [7:0]  data;
        logic        has_byte;
        logic        is_end;
    } sha_cmd_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_EMIT
    } sha_state_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big0(input logic [31:0] x);
        big0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big1(input logic [31:0] x);
        big1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

### rtl/sha_front.sv
// Front part: takes requests, drops empty ones and queues the rest for the core.
module sha_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        data_byte,
    input  logic              byte_present,
    input  logic              end_of_message,
    input  logic              push,
    output logic              full,
    output sha_pkg::sha_cmd_t cmd,
    output logic              cmd_valid,
    input  logic              cmd_take
);

    localparam int AW = $clog2(sha_pkg::QUEUE_DEPTH);

    sha_pkg::sha_cmd_t queue_mem [sha_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          do_write;
    logic          do_read;

    assign full      = (count_reg == (AW+1)'(sha_pkg::QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_mem[rd_ptr_reg];

    // Requests that carry neither a byte nor an end mark change nothing.
    assign do_write = push && !full && (byte_present || end_of_message);
    assign do_read  = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_write ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_read ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(do_write) - (AW+1)'(do_read);
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            queue_mem[wr_ptr_reg] <= '{data: data_byte, has_byte: byte_present,
                                       is_end: end_of_message};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(sha_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");
    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |=> (count_reg <= (AW+1)'(1)))
        else $error("queue count jumped from empty");
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !cmd_take) |=> full)
        else $error("full queue lost an entry");
`endif

endmodule

### rtl/sha_core.sv
// Core: block buffer, message schedule, round engine, padding and digest output.
module sha_core (
    input  logic              clk,
    input  logic              rst_n,
    input  sha_pkg::sha_cmd_t cmd,
    input  logic              cmd_valid,
    output logic              cmd_take,
    output logic [31:0]       digest_word,
    output logic [2:0]        word_index,
    output logic              last_word,
    output logic              empty,
    input  logic              pop
);

    sha_pkg::sha_state_t state_reg, state_next;

    logic [31:0] w_reg [16];     // sliding schedule window, also the block buffer
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [5:0]  fill_reg;
    logic [60:0] total_reg;
    logic [5:0]  round_reg;
    logic        final_reg;      // compression belongs to padding
    logic        lenblk_reg;     // next padding block holds the length
    logic [2:0]  emit_reg;

    logic        take_byte;
    logic [31:0] w_new;
    logic [31:0] w_cur;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ins_word;
    logic [63:0] bit_len;

    assign bit_len = {total_reg, 3'b000};
    assign w_cur   = w_reg[0];
    assign w_new   = sha_pkg::sig1(w_reg[14]) + w_reg[9]
                   + sha_pkg::sig0(w_reg[1]) + w_reg[0];

    assign t1 = v_reg[7] + sha_pkg::big1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + sha_pkg::K_TABLE[round_reg] + w_cur;
    assign t2 = sha_pkg::big0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign cmd_take  = (state_reg == sha_pkg::ST_FILL) && cmd_valid;
    assign take_byte = cmd_take && cmd.has_byte;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha_pkg::ST_FILL:
            begin
                if (cmd_take)
                begin
                    if (cmd.has_byte && fill_reg == 6'd63)
                        state_next = sha_pkg::ST_ROUND;
                    else if (cmd.is_end)
                        state_next = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_ROUND:
            begin
                if (round_reg == 6'd63)
                    state_next = sha_pkg::ST_UPDATE;
            end
            sha_pkg::ST_UPDATE:
            begin
                if (!final_reg)
                    state_next = sha_pkg::ST_FILL;
                else if (lenblk_reg)
                    state_next = sha_pkg::ST_PAD;
                else
                    state_next = sha_pkg::ST_EMIT;
            end
            sha_pkg::ST_PAD:
            begin
                state_next = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_EMIT:
            begin
                if (pop && emit_reg == 3'd7)
                    state_next = sha_pkg::ST_FILL;
            end
            default:
            begin
                state_next = sha_pkg::ST_FILL;
            end
        endcase
    end

    always_comb
    begin
        empty       = (state_reg != sha_pkg::ST_EMIT);
        digest_word = h_reg[emit_reg];
        word_index  = emit_reg;
        last_word   = (emit_reg == 3'd7);
    end

    // Byte insertion into the word under the fill pointer.
    always_comb
    begin
        ins_word = w_reg[fill_reg[5:2]];
        case (fill_reg[1:0])
            2'd0: ins_word[31:24] = cmd.data;
            2'd1: ins_word[23:16] = cmd.data;
            2'd2: ins_word[15:8]  = cmd.data;
            2'd3: ins_word[7:0]   = cmd.data;
            default: ins_word = ins_word;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            sha_pkg::ST_FILL:
            begin
                if (take_byte)
                    w_reg[fill_reg[5:2]] <= ins_word;
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            end
            sha_pkg::ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i+1];
                w_reg[15] <= w_new;
                v_reg[0] <= t1 + t2;
                v_reg[1] <= v_reg[0];
                v_reg[2] <= v_reg[1];
                v_reg[3] <= v_reg[2];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[5] <= v_reg[4];
                v_reg[6] <= v_reg[5];
                v_reg[7] <= v_reg[6];
            end
            sha_pkg::ST_UPDATE:
            begin
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i] + v_reg[i];
            end
            sha_pkg::ST_PAD:
            begin
                // Build the padding block from the partial one in a single step.
                for (int i = 0; i < 16; i++)
                begin
                    for (int b = 0; b < 4; b++)
                    begin
                        if (lenblk_reg || (4 * i + b) > int'(fill_reg))
                            w_reg[i][31-8*b -: 8] <= 8'h00;
                        else if ((4 * i + b) == int'(fill_reg))
                            w_reg[i][31-8*b -: 8] <= sha_pkg::PAD_BYTE;
                    end
                end
                if (lenblk_reg && fill_reg == 6'd0 && final_reg)
                    w_reg[0] <= {sha_pkg::PAD_BYTE, 24'h0};
                if (lenblk_reg || fill_reg < 6'(sha_pkg::LEN_POS))
                begin
                    w_reg[14] <= bit_len[63:32];
                    w_reg[15] <= bit_len[31:0];
                end
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha_pkg::ST_FILL;
            fill_reg   <= '0;
            total_reg  <= '0;
            round_reg  <= '0;
            final_reg  <= 1'b0;
            lenblk_reg <= 1'b0;
            emit_reg   <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha_pkg::H_INIT[i];
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                sha_pkg::ST_FILL:
                begin
                    if (take_byte)
                    begin
                        fill_reg  <= fill_reg + 6'd1;
                        total_reg <= total_reg + 61'd1;
                    end
                    if (cmd_take && cmd.is_end)
                    begin
                        final_reg  <= 1'b1;
                        // An end that brings the 64th byte pads a fresh block
                        // once the full one is compressed.
                        lenblk_reg <= take_byte && (fill_reg == 6'd63);
                    end
                    else if (cmd_take)
                        final_reg <= 1'b0;
                    round_reg <= '0;
                end
                sha_pkg::ST_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                end
                sha_pkg::ST_UPDATE:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    emit_reg <= '0;
                end
                sha_pkg::ST_PAD:
                begin
                    round_reg <= '0;
                    if (!lenblk_reg && fill_reg >= 6'(sha_pkg::LEN_POS))
                        lenblk_reg <= 1'b1;     // length needs an extra block
                    else
                        lenblk_reg <= 1'b0;
                    if (lenblk_reg)
                        fill_reg <= 6'd63;      // pad byte already placed
                end
                sha_pkg::ST_EMIT:
                begin
                    if (pop)
                    begin
                        emit_reg <= emit_reg + 3'd1;
                        if (emit_reg == 3'd7)
                        begin
                            fill_reg   <= '0;
                            total_reg  <= '0;
                            final_reg  <= 1'b0;
                            lenblk_reg <= 1'b0;
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= sha_pkg::H_INIT[i];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_round_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_ROUND && round_reg == 6'd63)
        |=> (state_reg == sha_pkg::ST_UPDATE))
        else $error("round count did not end the compression");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_EMIT && !pop) |=> $stable(emit_reg))
        else $error("digest index moved without a pop");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sha_pkg::ST_FILL) |-> !cmd_take)
        else $error("command taken while core busy");
`endif

endmodule

### rtl/sha256_stream_hasher_top.sv
// Top level of the SHA-256 stream hasher.
// The hasher takes a message one byte per request and returns the eight 32-bit
// SHA-256 digest words, first word first, after a request marked end_of_message.
// A request with byte_present low carries no byte, so an end request alone
// gives the digest of the empty message; a request with neither flag set is
// dropped. Requests enter a four-entry queue, so push is held off only when
// that queue is full. The core takes one byte per cycle into the block buffer
// while it fills a block; each 64th byte starts a compression of 64 rounds,
// one round per cycle, followed by a step that adds the result into the hash
// words, and no byte is taken until that block is done. The end request costs
// a padding step per padding block and one or two compressions, the second when
// more than 55 bytes are in the last block or when the
// end request itself brings the 64th byte. The digest is then read with pop,
// one word per request, and the hasher starts a fresh message after the eighth
// word. The bit length is taken modulo 2^64.
module sha256_stream_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    input  logic        push,
    output logic        full,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    output logic        empty,
    input  logic        pop
);

    sha_pkg::sha_cmd_t cmd;
    logic              cmd_valid;
    logic              cmd_take;

    sha_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .push           (push),
        .full           (full),
        .cmd            (cmd),
        .cmd_valid      (cmd_valid),
        .cmd_take       (cmd_take)
    );

    sha_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cmd_valid   (cmd_valid),
        .cmd_take    (cmd_take),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word),
        .empty       (empty),
        .pop         (pop)
    );

endmodule
